// ===== design/afls_pkg.sv =====
`timescale 1ns / 1ps

package afls_pkg;

   // Fixed field widths of the stream words.
   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 16;
   localparam int LEVEL_W    = 17;
   localparam int WEIGHT_W   = 16;
   localparam int OUT_W      = 18;
   localparam int PROD_W     = WEIGHT_W + LEVEL_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int RAD_W      = 34;
   localparam int FRAC_W     = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   // Square root runs one bit pair per step over a radicand below 2^34.
   localparam int ROOT_STEPS = 17;
   // Four taps plus one trailing add.
   localparam int MAC_STEPS  = 5;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_WEIGHT_OLDEST   = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WEIGHT_OLDER    = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_WEIGHT_PREVIOUS = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_WEIGHT_NEWEST   = 8'd3;

   // Weight reset values, Q0.16.
   localparam logic [WEIGHT_W-1:0] WEIGHT_OLDEST_RST   = 16'd786;
   localparam logic [WEIGHT_W-1:0] WEIGHT_OLDER_RST    = 16'd7995;
   localparam logic [WEIGHT_W-1:0] WEIGHT_PREVIOUS_RST = 16'd31719;
   localparam logic [WEIGHT_W-1:0] WEIGHT_NEWEST_RST   = 16'd50201;

   // Multiply-accumulate tap codes.
   localparam logic [1:0] TAP_OLDEST   = 2'd0;
   localparam logic [1:0] TAP_OLDER    = 2'd1;
   localparam logic [1:0] TAP_PREVIOUS = 2'd2;
   localparam logic [1:0] TAP_NEWEST   = 2'd3;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_ROOT,
      ST_WEIGHT,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       cfg_write;
      logic       sample_en;
      logic       frame_close;
      logic       div_step;
      logic       root_start;
      logic       root_step;
      logic       mac_mul;
      logic       mac_add;
      logic [1:0] mac_tap;
      logic       out_load;
   } cmd_type;

endpackage

// ===== design/afls_ctrl.sv =====
`timescale 1ns / 1ps

module afls_ctrl #(
   parameter int DIV_STEPS = 27
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_valid,
   output logic                csr_ready,
   output afls_pkg::cmd_type   cmd
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   afls_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign csr_ready  = 1'b1;

   // State, step counter and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afls_pkg::ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.cfg_write = csr_valid;
      cmd.mac_tap   = step_ff[1:0];

      case (state_ff)
         afls_pkg::ST_ACCUM: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.sample_en = 1'b1;
               if (req_tlast) begin
                  cmd.frame_close = 1'b1;
                  step_in         = '0;
                  state_in        = afls_pkg::ST_DIVIDE;
               end
            end
         end
         afls_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               cmd.root_start = 1'b1;
               step_in        = '0;
               state_in       = afls_pkg::ST_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         afls_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == STEP_W'(afls_pkg::ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = afls_pkg::ST_WEIGHT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         afls_pkg::ST_WEIGHT: begin
            // Multiply on the first four steps, add the registered product
            // on the last four.
            cmd.mac_mul = (step_ff != STEP_W'(afls_pkg::MAC_STEPS - 1));
            cmd.mac_add = (step_ff != '0);
            if (step_ff == STEP_W'(afls_pkg::MAC_STEPS - 1)) begin
               step_in  = '0;
               state_in = afls_pkg::ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         afls_pkg::ST_EMIT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = afls_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = afls_pkg::ST_ACCUM;
         end
      endcase
   end

endmodule

// ===== design/afls_datapath.sv =====
`timescale 1ns / 1ps

module afls_datapath #(
   parameter int MAX_FRAME = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  afls_pkg::cmd_type                      cmd,
   input  logic signed [afls_pkg::SAMPLE_W-1:0]   sample,
   input  logic [afls_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [afls_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic [afls_pkg::OUT_W-1:0]             smoothed_level
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int SUM_W = CNT_W + 15;
   localparam int NUM_W = SUM_W + 1;

   // Weight registers.
   logic [afls_pkg::WEIGHT_W-1:0] w_oldest_ff, w_older_ff, w_previous_ff, w_newest_ff;
   // Frame accumulator.
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [afls_pkg::MAG_W-1:0]    mag;
   // Divider.
   logic [NUM_W-1:0]              num_ff;
   logic [CNT_W-1:0]              den_ff, rem_ff, rem_in;
   logic [afls_pkg::LEVEL_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]                trial;
   logic                          trial_ge;
   // Square root.
   logic [afls_pkg::RAD_W-1:0]    rad_ff, root_ff, bit_ff;
   logic [afls_pkg::RAD_W-1:0]    root_trial;
   // Level history and weighted sum.
   logic [afls_pkg::LEVEL_W-1:0]  hist0_ff, hist1_ff, hist2_ff;
   logic [afls_pkg::LEVEL_W-1:0]  level;
   logic [afls_pkg::WEIGHT_W-1:0] w_sel;
   logic [afls_pkg::LEVEL_W-1:0]  h_sel;
   logic [afls_pkg::PROD_W-1:0]   prod_ff;
   logic [afls_pkg::ACC_W-1:0]    acc_ff;
   logic [afls_pkg::OUT_W-1:0]    out_ff;

   assign level          = root_ff[afls_pkg::LEVEL_W-1:0];
   assign smoothed_level = out_ff;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_oldest_ff   <= afls_pkg::WEIGHT_OLDEST_RST;
         w_older_ff    <= afls_pkg::WEIGHT_OLDER_RST;
         w_previous_ff <= afls_pkg::WEIGHT_PREVIOUS_RST;
         w_newest_ff   <= afls_pkg::WEIGHT_NEWEST_RST;
      end else if (cmd.cfg_write) begin
         case (csr_index)
            afls_pkg::REG_WEIGHT_OLDEST:   w_oldest_ff   <= csr_wdata;
            afls_pkg::REG_WEIGHT_OLDER:    w_older_ff    <= csr_wdata;
            afls_pkg::REG_WEIGHT_PREVIOUS: w_previous_ff <= csr_wdata;
            afls_pkg::REG_WEIGHT_NEWEST:   w_newest_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Magnitude of the sample; the most negative value maps to 32768.
   assign mag = sample[afls_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;

   // Samples past a full count are ignored until the frame closes.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (count_ff < CNT_W'(MAX_FRAME)) begin
         sum_in   = sum_ff + SUM_W'(mag);
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.frame_close) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.sample_en) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // Restoring divider: one quotient bit per step of twice the sum by
   // the count. The quotient never exceeds 65536, so 17 bits hold it.
   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});
   assign rem_in   = trial_ge ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
   assign quo_in   = {quo_ff[afls_pkg::LEVEL_W-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (cmd.frame_close) begin
         num_ff <= {sum_in, 1'b0};
         den_ff <= count_in;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Bit-pair square root of the quotient, twice the mean magnitude, scaled by 2^16.
   assign root_trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         rad_ff  <= {1'b0, quo_in, afls_pkg::FRAC_W'(0)};
         root_ff <= '0;
         bit_ff  <= afls_pkg::RAD_W'(1) << 32;
      end else if (cmd.root_step) begin
         if (rad_ff >= root_trial) begin
            rad_ff  <= rad_ff - root_trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Tap selection for the weighted sum.
   always_comb begin
      case (cmd.mac_tap)
         afls_pkg::TAP_OLDEST: begin
            w_sel = w_oldest_ff;
            h_sel = hist0_ff;
         end
         afls_pkg::TAP_OLDER: begin
            w_sel = w_older_ff;
            h_sel = hist1_ff;
         end
         afls_pkg::TAP_PREVIOUS: begin
            w_sel = w_previous_ff;
            h_sel = hist2_ff;
         end
         default: begin
            w_sel = w_newest_ff;
            h_sel = level;
         end
      endcase
   end

   // One multiply per step into a product register, then accumulate.
   always_ff @(posedge clock) begin
      if (cmd.mac_mul) begin
         prod_ff <= afls_pkg::PROD_W'(w_sel) * afls_pkg::PROD_W'(h_sel);
      end
      if (cmd.frame_close) begin
         acc_ff <= '0;
      end else if (cmd.mac_add) begin
         acc_ff <= acc_ff + afls_pkg::ACC_W'(prod_ff);
      end
   end

   // Output word and level history update.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= acc_ff[afls_pkg::FRAC_W +: afls_pkg::OUT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff <= '0;
         hist1_ff <= '0;
         hist2_ff <= '0;
      end else if (cmd.out_load) begin
         hist0_ff <= hist1_ff;
         hist1_ff <= hist2_ff;
         hist2_ff <= level;
      end
   end

endmodule

// ===== design/audio_frame_level_smoother_unit.sv =====
`timescale 1ns / 1ps
// Channel | Ports          | Word contents (low bit first)
// req     | req_t*         | tdata: sample[15:0]; tlast: frame_end
// rsp     | rsp_t*         | tdata: smoothed_level[17:0], zero padded to 24 bits
// csr     | csr_*          | csr_index: register index; csr_wdata: weight
//
// Samples are taken one per cycle while a frame accumulates.
// After the closing word come CNT_W + 16 divider steps (27 at MAX_FRAME 1024), 17 root
// steps and 5 multiply-accumulate steps, then the output register is loaded.
// Reset clears the accumulator, level history and output valid and restores weights.
// A result waiting on rsp does not block new samples; only the next frame's load
// waits for the output register to drain.

module audio_frame_level_smoother_unit #(
   parameter int MAX_FRAME = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // sample[15:0]
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // smoothed_level[17:0], zeros above
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CNT_W     = $clog2(MAX_FRAME + 1);
   localparam int DIV_STEPS = CNT_W + 16;

   afls_pkg::cmd_type            cmd;
   logic [afls_pkg::OUT_W-1:0]   smoothed_level;

   afls_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .cmd        (cmd)
   );

   afls_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sample         (req_tdata),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .smoothed_level (smoothed_level)
   );

   assign rsp_tdata = {6'b0, smoothed_level};

   // A closing word stops intake until the result is loaded.
   a_close_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still taken after frame close");

   // The output register is only loaded when its previous word has left.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output word overwritten");

   // Datapath phases never overlap.
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sample_en, cmd.div_step, cmd.root_step,
                cmd.mac_mul || cmd.mac_add, cmd.out_load}))
      else $error("overlapping datapath commands");

   // A loaded result is presented in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

// ===== dv/tb_audio_frame_level_smoother_unit.sv =====
`timescale 1ns / 1ps

module tb_audio_frame_level_smoother_unit;
   import afls_pkg::*;

   localparam int MAX_FRAME      = 1024;
   // Margin after each phase for the division, root, taps and output load of a frame.
   localparam int CLOSE_LATENCY  = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 2;
   localparam int PHASE_WORDS    = 60;
   localparam int MAX_REPORTS    = 10;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_TOP = '1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_end;
   } sample_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // sample[15:0]
   logic                req_tlast = 1'b0; // frame_end
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;        // smoothed_level[17:0], zeros above
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [7:0]          csr_index = '0;
   logic [15:0]         csr_wdata = '0;

   // Words waiting for the driver and levels waiting for the output side.
   sample_word_type     pending_words[$];
   logic [OUT_W-1:0]    level_expect_q[$];
   int                  words_queued = 0;
   int                  words_taken = 0;
   int                  mismatch_count = 0;

   // Predictor state: weights by register index, accumulator and level history.
   logic [WEIGHT_W-1:0] weight_by_index [4];
   logic [25:0]         mag_total;
   logic [10:0]         taken_count;
   logic [LEVEL_W-1:0]  past_levels [3];

   audio_frame_level_smoother_unit #(
      .MAX_FRAME(MAX_FRAME)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Floor of the square root, built up one result bit at a time from the top.
   function automatic logic [LEVEL_W-1:0] floor_root(input logic [63:0] radicand);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = LEVEL_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) begin
            root = trial;
         end
      end
      return root[LEVEL_W-1:0];
   endfunction

   // Accumulate one accepted word; a closing word yields the expected level.
   task automatic predict_level(input logic signed [SAMPLE_W-1:0] sample,
                                input logic frame_end);
      logic [16:0] magnitude;
      logic [63:0] mean;
      logic [63:0] level;
      logic [63:0] weighted;
      magnitude = sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
      if (taken_count < MAX_FRAME) begin
         mag_total   = mag_total + magnitude;
         taken_count = taken_count + 1'b1;
      end
      if (frame_end) begin
         mean = (64'(mag_total) * 2) / taken_count;
         if (mean > 65536) begin
            mean = 65536;
         end
         level = 64'(floor_root(mean << FRAC_W));
         weighted = 64'(weight_by_index[REG_WEIGHT_OLDEST]) * past_levels[0]
                  + 64'(weight_by_index[REG_WEIGHT_OLDER]) * past_levels[1]
                  + 64'(weight_by_index[REG_WEIGHT_PREVIOUS]) * past_levels[2]
                  + 64'(weight_by_index[REG_WEIGHT_NEWEST]) * level;
         level_expect_q.push_back(weighted[FRAC_W +: OUT_W]);
         past_levels[0] = past_levels[1];
         past_levels[1] = past_levels[2];
         past_levels[2] = level[LEVEL_W-1:0];
         mag_total      = '0;
         taken_count    = '0;
      end
   endtask

   // Biased sample mix: full-scale values, silence, quiet signal and noise.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0: s = -16'sd32768;
         1: s = 16'sd32767;
         2: s = '0;
         3: begin
            s = SAMPLE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
               s = -s;
            end
         end
         default: s = SAMPLE_W'($urandom());
      endcase
      return s;
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return WEIGHT_W'($urandom());
      endcase
   endfunction

   task automatic queue_word(input logic signed [SAMPLE_W-1:0] sample,
                             input logic frame_end);
      sample_word_type w;
      w.sample    = sample;
      w.frame_end = frame_end;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic queue_frame(input int length);
      for (int i = 0; i < length; i++) begin
         queue_word(pick_sample(), i == length - 1);
      end
   endtask

   // One register write over the configuration channel; the predictor follows it.
   task automatic write_weight(input logic [CSR_ADDR_W-1:0] index,
                               input logic [WEIGHT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (index)
         REG_WEIGHT_OLDEST, REG_WEIGHT_OLDER, REG_WEIGHT_PREVIOUS, REG_WEIGHT_NEWEST: begin
            weight_by_index[index[1:0]] = value;
         end
         default: begin
         end
      endcase
   endtask

   task automatic write_all_weights(input logic [WEIGHT_W-1:0] oldest,
                                    input logic [WEIGHT_W-1:0] older,
                                    input logic [WEIGHT_W-1:0] previous,
                                    input logic [WEIGHT_W-1:0] newest);
      write_weight(REG_WEIGHT_OLDEST, oldest);
      write_weight(REG_WEIGHT_OLDER, older);
      write_weight(REG_WEIGHT_PREVIOUS, previous);
      write_weight(REG_WEIGHT_NEWEST, newest);
   endtask

   // Wait until every queued word is taken and every level has come out,
   // then give the block time to finish any frame-end work.
   task automatic drain_phase();
      while (words_taken != words_queued || level_expect_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (CLOSE_LATENCY) @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // Hold the word until it is taken.
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
      end else if (pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= w.sample;
         req_tlast  <= w.frame_end;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 12);
            case ($urandom_range(0, 19))
               0, 1, 2:    gap_left = $urandom_range(20, 40);
               3, 4, 5, 6, 7, 8, 9: gap_left = $urandom_range(3, 10);
               default:    gap_left = $urandom_range(0, 2);
            endcase
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: ready follows a repeating random 16-bit pattern, redrawn periodically, often all ready.
   int          rx_tick = 0;
   logic [15:0] stall_pattern = '1;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_tick % 64 == 0) begin
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom());
         end
         rsp_tready <= stall_pattern[rx_tick % 16];
         rx_tick++;
      end
   end

   // Monitor: check each result word against the oldest expected level,
   // and feed each accepted sample word to the predictor.
   always @(posedge clock) begin
      logic [OUT_W-1:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (level_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected result word: smoothed_level=%0d tdata=%h",
                           rsp_tdata[OUT_W-1:0], rsp_tdata);
               end
            end else begin
               want = level_expect_q.pop_front();
               if (rsp_tdata !== {{(24 - OUT_W){1'b0}}, want}) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("smoothed_level mismatch: expected %0d, got %0d (tdata=%h)",
                              want, rsp_tdata[OUT_W-1:0], rsp_tdata);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_level(req_tdata, req_tlast);
            words_taken++;
         end
      end
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int target;
      weight_by_index[REG_WEIGHT_OLDEST]   = WEIGHT_OLDEST_RST;
      weight_by_index[REG_WEIGHT_OLDER]    = WEIGHT_OLDER_RST;
      weight_by_index[REG_WEIGHT_PREVIOUS] = WEIGHT_PREVIOUS_RST;
      weight_by_index[REG_WEIGHT_NEWEST]   = WEIGHT_NEWEST_RST;
      mag_total   = '0;
      taken_count = '0;
      past_levels[0] = '0;
      past_levels[1] = '0;
      past_levels[2] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset weights: single-word frames at full scale and silence, then
      // mixed frames so every history tap holds a distinct level.
      queue_word(-16'sd32768, 1'b1);
      queue_word(16'sd32767, 1'b1);
      queue_word('0, 1'b1);
      queue_word(-16'sd1, 1'b0);
      queue_word(16'sd1, 1'b0);
      queue_word(-16'sd32768, 1'b0);
      queue_word(16'sd32767, 1'b1);
      queue_word(16'sh5555, 1'b0);
      queue_word(16'shAAAA, 1'b0);
      queue_word(16'sh00FF, 1'b1);
      queue_word(-16'sd2, 1'b0);
      queue_word(16'sh7F00, 1'b1);
      drain_phase();

      // Largest weights on a full history of full-scale levels gives the top output.
      // Writes to indexes past the last register must change nothing.
      write_all_weights('1, '1, '1, '1);
      write_weight(REG_WEIGHT_NEWEST + 1'b1, '0);
      write_weight(CSR_INDEX_TOP, '0);
      repeat (4) queue_word(-16'sd32768, 1'b1);
      drain_phase();

      // All weights cleared: output must be zero whatever the level.
      write_all_weights('0, '0, '0, '0);
      queue_word(16'sd32767, 1'b1);
      queue_word(-16'sd12345, 1'b0);
      queue_word(16'sd4321, 1'b1);
      drain_phase();

      // Overlong frame: words past the frame limit, the closing one too, are dropped.
      // A short frame after it shows the count starts over.
      write_all_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight());
      for (int i = 0; i < MAX_FRAME + 5; i++) begin
         queue_word(i < MAX_FRAME ? pick_sample() : -16'sd32768, 1'b0);
      end
      queue_word(-16'sd32768, 1'b1);
      queue_frame(3);
      drain_phase();

      // Random phases, each under its own weight setting.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_all_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight());
         if ($urandom_range(0, 1) == 1) begin
            write_weight(CSR_ADDR_W'($urandom_range(REG_WEIGHT_NEWEST + 1, CSR_INDEX_TOP)),
                         WEIGHT_W'($urandom()));
         end
         target = words_queued + PHASE_WORDS;
         while (words_queued < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: queue_frame($urandom_range(1, 8));
               6, 7, 8:          queue_frame($urandom_range(9, 40));
               default:          queue_frame($urandom_range(41, 120));
            endcase
         end
         drain_phase();
      end

      // Back to the reset weights for a final short stretch.
      write_all_weights(WEIGHT_OLDEST_RST, WEIGHT_OLDER_RST, WEIGHT_PREVIOUS_RST,
                        WEIGHT_NEWEST_RST);
      repeat (6) queue_frame($urandom_range(1, 6));
      drain_phase();

      if (mismatch_count == 0 && level_expect_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
